>>> sv/crvg_pkg.sv
package crvg_pkg;

    localparam int SLICE_COUNT_DEF = 20;
    localparam int SLICE_MIN       = 3;
    localparam int SLICE_MAX       = 32;
    localparam int IDX_W           = 5;
    localparam int CS_W            = 20;
    localparam int N_W             = 18;
    localparam int W_W             = 20;
    localparam int NE_W            = 34;
    localparam int PT_W            = 26;
    localparam int ACC_W           = 48;
    localparam int QUEUE_DEPTH     = 2;

    localparam longint ATAN_TAB [16] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
        64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
        64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D
    };

    typedef enum logic [3:0] {
        F_IDLE, F_SQ, F_SQRT, F_DIV, F_DOT, F_PROJ, F_CROSS, F_NE, F_PUSH
    } t_fstate;

    typedef struct packed {
        logic [2:0][31:0]     base;
        logic [30:0]          radius;
        logic [2:0][N_W-1:0]  u;
        logic [2:0][W_W-1:0]  w;
        logic [2:0][NE_W-1:0] ne;
        logic                 degen;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    function automatic int slice_clamp(input int s);
        int r;
        r = s;
        if (r < SLICE_MIN) r = SLICE_MIN;
        if (r > SLICE_MAX) r = SLICE_MAX;
        return r;
    endfunction

    function automatic logic [2*CS_W-1:0] cordic_cs(input longint phase);
        longint     z, x, y, nx, c, s;
        logic [1:0] quad;
        quad = phase[31:30];
        z = phase & 64'h3FFFFFFF;
        x = 39796;
        y = 0;
        for (int k = 0; k < 16; k++) begin
            if (z >= 0) begin
                nx = x - (y >>> k);
                y  = y + (x >>> k);
                z  = z - ATAN_TAB[k];
            end else begin
                nx = x + (y >>> k);
                y  = y - (x >>> k);
                z  = z + ATAN_TAB[k];
            end
            x = nx;
        end
        unique case (quad)
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
        return {c[CS_W-1:0], s[CS_W-1:0]};
    endfunction

    function automatic logic [31:0] sat32(input logic signed [ACC_W-1:0] v);
        logic [31:0] r;
        if (v > $signed(ACC_W'(32'h7FFFFFFF)))
            r = 32'h7FFFFFFF;
        else if (v < $signed({{(ACC_W-32){1'b1}}, 32'h80000000}))
            r = 32'h80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

>>> sv/cylinder_rim_vertex_generator_top.sv
// channel   dir  handshake                   payload
// in        in   i_in_valid / o_in_ready     base, rim_radius, axis, extent, seed
// out       out  o_out_valid / i_out_ready   pos, is_top, slice_index, degenerate, last
//
// front per item: two 32-step square roots and two 17-step three-lane divides dominate;
// the back then gives one vertex a cycle when the queue holds a job and out does not stall,
// 2*Slices per item (SLICE_COUNT clamped to 3..32), through a three-stage pipeline
// a two-entry job queue lets the front start the next item while the back drains
// synchronous active-low reset clears control only; out stalls freeze the back pipeline
module cylinder_rim_vertex_generator_top import crvg_pkg::*; #(
    parameter int SLICE_COUNT = SLICE_COUNT_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [31:0]      i_base_x,
    input  logic [31:0]      i_base_y,
    input  logic [31:0]      i_base_z,
    input  logic [30:0]      i_rim_radius,
    input  logic [31:0]      i_axis_x,
    input  logic [31:0]      i_axis_y,
    input  logic [31:0]      i_axis_z,
    input  logic [31:0]      i_extent,
    input  logic [15:0]      i_seed_x,
    input  logic [15:0]      i_seed_y,
    input  logic [15:0]      i_seed_z,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [31:0]      o_pos_x,
    output logic [31:0]      o_pos_y,
    output logic [31:0]      o_pos_z,
    output logic             o_is_top,
    output logic [IDX_W-1:0] o_slice_index,
    output logic             o_degenerate,
    output logic             o_last
);
    localparam int Slices = slice_clamp(SLICE_COUNT);

    t_job   w_job, w_head;
    t_qstat w_qstat;
    logic   w_push, w_pop;

    crvg_front u_front (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_ready,
        .i_base_x, .i_base_y, .i_base_z, .i_rim_radius,
        .i_axis_x, .i_axis_y, .i_axis_z, .i_extent,
        .i_seed_x, .i_seed_y, .i_seed_z,
        .i_qstat(w_qstat), .o_push(w_push), .o_job(w_job)
    );

    crvg_queue u_queue (
        .i_clk, .i_rst_n, .i_push(w_push), .i_job(w_job),
        .i_pop(w_pop), .o_head(w_head), .o_stat(w_qstat)
    );

    crvg_back #(.SLICE_COUNT(SLICE_COUNT)) u_back (
        .i_clk, .i_rst_n, .i_head(w_head), .i_qstat(w_qstat), .o_pop(w_pop),
        .o_out_valid, .i_out_ready, .o_pos_x, .o_pos_y, .o_pos_z,
        .o_is_top, .o_slice_index, .o_degenerate, .o_last
    );

    a_last_is_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last |-> o_is_top)
        else $error("last vertex is not a top vertex");

    a_last_slice: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last |-> o_slice_index == IDX_W'(Slices - 1))
        else $error("last vertex on wrong slice");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_qstat.full)
        else $error("job queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_qstat.empty)
        else $error("job queue underflow");
endmodule

>>> sv/crvg_queue.sv
module crvg_queue import crvg_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_job   i_job,
    input  logic   i_pop,
    output t_job   o_head,
    output t_qstat o_stat
);
    localparam int PW = $clog2(QUEUE_DEPTH);

    t_job         r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [PW:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= PW'(r_wr + 1'b1);
            if (i_pop)  r_rd <= PW'(r_rd + 1'b1);
            r_cnt <= (PW+1)'(r_cnt + i_push - i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_job;
    end

    assign o_head       = r_mem[r_rd];
    assign o_stat.full  = (r_cnt == (PW+1)'(QUEUE_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
endmodule

>>> sv/crvg_front.sv
module crvg_front import crvg_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_base_x,
    input  logic [31:0] i_base_y,
    input  logic [31:0] i_base_z,
    input  logic [30:0] i_rim_radius,
    input  logic [31:0] i_axis_x,
    input  logic [31:0] i_axis_y,
    input  logic [31:0] i_axis_z,
    input  logic [31:0] i_extent,
    input  logic [15:0] i_seed_x,
    input  logic [15:0] i_seed_y,
    input  logic [15:0] i_seed_z,
    input  t_qstat      i_qstat,
    output logic        o_push,
    output t_job        o_job
);
    localparam logic [4:0] SQRT_LAST = 5'd31;
    localparam logic [4:0] DIV_LAST  = 5'd16;

    t_fstate r_state, n_state;

    logic [31:0]              r_base [3], n_base [3];
    logic [30:0]              r_radius, n_radius;
    logic signed [31:0]       r_ext, n_ext;
    logic [15:0]              r_seed [3], n_seed [3];
    logic signed [31:0]       r_vec [3], n_vec [3];
    logic [1:0]               r_k, n_k;
    logic                     r_proj, n_proj;
    logic [63:0]              r_acc, n_acc;
    logic [63:0]              r_bit, n_bit;
    logic [63:0]              r_res, n_res;
    logic [4:0]               r_cnt, n_cnt;
    logic [32:0]              r_len, n_len;
    logic [32:0]              r_rem [3], n_rem [3];
    logic [16:0]              r_q [3], n_q [3];
    logic                     r_lsb [3], n_lsb [3];
    logic                     r_neg [3], n_neg [3];
    logic signed [N_W-1:0]    r_n [3], n_n [3];
    logic signed [N_W-1:0]    r_u [3], n_u [3];
    logic signed [W_W-1:0]    r_w [3], n_w [3];
    logic signed [NE_W-1:0]   r_ne [3], n_ne [3];
    logic signed [19:0]       r_dotv, n_dotv;
    logic                     r_degen, n_degen;

    logic [31:0]        w_sq_mag;
    logic [63:0]        w_trial;
    logic signed [34:0] w_dot_term;
    logic signed [37:0] w_nd;
    logic signed [31:0] w_p;
    logic signed [N_W-1:0] w_na, w_nb, w_ua, w_ub;
    logic signed [36:0] w_cr;
    logic signed [49:0] w_nep;
    logic signed [63:0] w_dot_sh;
    logic [33:0]        w_rem2 [3];
    logic               w_ge [3];
    logic [16:0]        w_qn [3];
    logic [31:0]        w_lmag [3];
    logic               w_load;

    assign w_sq_mag   = r_vec[r_k][31] ? (32'd0 - r_vec[r_k]) : r_vec[r_k];
    assign w_trial    = r_res + r_bit;
    assign w_dot_term = r_n[r_k] * $signed({1'b0, r_seed[r_k]});
    assign w_nd       = r_n[r_k] * r_dotv;
    assign w_p        = $signed({16'd0, r_seed[r_k]}) - 32'(w_nd >>> 16);
    assign w_cr       = 37'(w_na * w_ub) - 37'(w_nb * w_ua);
    assign w_nep      = r_n[r_k] * r_ext;

    always_comb begin
        unique case (r_k)
            2'd0:    begin w_na = r_n[1]; w_ub = r_u[2]; w_nb = r_n[2]; w_ua = r_u[1]; end
            2'd1:    begin w_na = r_n[2]; w_ub = r_u[0]; w_nb = r_n[0]; w_ua = r_u[2]; end
            default: begin w_na = r_n[0]; w_ub = r_u[1]; w_nb = r_n[1]; w_ua = r_u[0]; end
        endcase
    end

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_rem2[j] = {r_rem[j], (r_cnt == '0) ? r_lsb[j] : 1'b0};
            w_ge[j]   = w_rem2[j] >= {1'b0, r_len};
            w_qn[j]   = {r_q[j][15:0], w_ge[j]};
            w_lmag[j] = r_vec[j][31] ? (32'd0 - r_vec[j]) : r_vec[j];
        end
    end

    always_comb begin
        n_state  = r_state;
        n_base   = r_base;
        n_radius = r_radius;
        n_ext    = r_ext;
        n_seed   = r_seed;
        n_vec    = r_vec;
        n_k      = r_k;
        n_proj   = r_proj;
        n_acc    = r_acc;
        n_bit    = r_bit;
        n_res    = r_res;
        n_cnt    = r_cnt;
        n_len    = r_len;
        n_rem    = r_rem;
        n_q      = r_q;
        n_lsb    = r_lsb;
        n_neg    = r_neg;
        n_n      = r_n;
        n_u      = r_u;
        n_w      = r_w;
        n_ne     = r_ne;
        n_dotv   = r_dotv;
        n_degen  = r_degen;
        w_dot_sh = '0;
        w_load   = 1'b0;
        o_push   = 1'b0;
        o_in_ready = 1'b0;

        unique case (r_state)
            F_IDLE: begin
                o_in_ready = 1'b1;
                w_load     = i_in_valid;
            end
            F_SQ: begin
                n_acc = r_acc + 64'(w_sq_mag) * 64'(w_sq_mag);
                n_k   = 2'(r_k + 1'b1);
                if (r_k == 2'd2) begin
                    n_state = F_SQRT;
                    n_bit   = 64'd1 << 62;
                    n_res   = '0;
                    n_cnt   = '0;
                end
            end
            F_SQRT: begin
                if (r_acc >= w_trial) begin
                    n_acc = r_acc - w_trial;
                    n_res = (r_res >> 1) + r_bit;
                end else begin
                    n_res = r_res >> 1;
                end
                n_bit = r_bit >> 2;
                n_cnt = 5'(r_cnt + 1'b1);
                if (r_cnt == SQRT_LAST) begin
                    n_len = n_res[32:0];
                    n_cnt = '0;
                    if (n_res == '0) begin
                        n_degen = 1'b1;
                        n_state = F_PUSH;
                    end else begin
                        n_state = F_DIV;
                        for (int j = 0; j < 3; j++) begin
                            n_rem[j] = 33'(w_lmag[j] >> 1);
                            n_lsb[j] = w_lmag[j][0];
                            n_neg[j] = r_vec[j][31];
                            n_q[j]   = '0;
                        end
                    end
                end
            end
            F_DIV: begin
                for (int j = 0; j < 3; j++) begin
                    n_rem[j] = w_ge[j] ? 33'(w_rem2[j] - {1'b0, r_len}) : w_rem2[j][32:0];
                    n_q[j]   = w_qn[j];
                end
                n_cnt = 5'(r_cnt + 1'b1);
                if (r_cnt == DIV_LAST) begin
                    n_k   = '0;
                    n_acc = '0;
                    for (int j = 0; j < 3; j++) begin
                        if (r_proj)
                            n_u[j] = r_neg[j] ? (N_W'(0) - N_W'(w_qn[j])) : N_W'(w_qn[j]);
                        else
                            n_n[j] = r_neg[j] ? (N_W'(0) - N_W'(w_qn[j])) : N_W'(w_qn[j]);
                    end
                    n_state = r_proj ? F_CROSS : F_DOT;
                end
            end
            F_DOT: begin
                n_acc = r_acc + 64'(w_dot_term);
                n_k   = 2'(r_k + 1'b1);
                if (r_k == 2'd2) begin
                    w_dot_sh = $signed(n_acc) >>> 16;
                    n_dotv   = w_dot_sh[19:0];
                    n_k      = '0;
                    n_state  = F_PROJ;
                end
            end
            F_PROJ: begin
                n_vec[r_k] = w_p;
                n_k        = 2'(r_k + 1'b1);
                if (r_k == 2'd2) begin
                    n_k     = '0;
                    n_acc   = '0;
                    n_proj  = 1'b1;
                    n_state = F_SQ;
                end
            end
            F_CROSS: begin
                n_w[r_k] = W_W'(w_cr >>> 16);
                n_k      = 2'(r_k + 1'b1);
                if (r_k == 2'd2) begin
                    n_k     = '0;
                    n_state = F_NE;
                end
            end
            F_NE: begin
                n_ne[r_k] = NE_W'(w_nep >>> 16);
                n_k       = 2'(r_k + 1'b1);
                if (r_k == 2'd2) n_state = F_PUSH;
            end
            F_PUSH: begin
                if (!i_qstat.full) begin
                    o_push     = 1'b1;
                    o_in_ready = 1'b1;
                    w_load     = i_in_valid;
                    n_state    = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase

        if (w_load) begin
            n_base   = '{i_base_x, i_base_y, i_base_z};
            n_radius = i_rim_radius;
            n_ext    = i_extent;
            n_seed   = '{i_seed_x, i_seed_y, i_seed_z};
            n_vec    = '{i_axis_x, i_axis_y, i_axis_z};
            n_k      = '0;
            n_proj   = 1'b0;
            n_acc    = '0;
            n_degen  = 1'b0;
            n_state  = F_SQ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_base   <= n_base;
        r_radius <= n_radius;
        r_ext    <= n_ext;
        r_seed   <= n_seed;
        r_vec    <= n_vec;
        r_k      <= n_k;
        r_proj   <= n_proj;
        r_acc    <= n_acc;
        r_bit    <= n_bit;
        r_res    <= n_res;
        r_cnt    <= n_cnt;
        r_len    <= n_len;
        r_rem    <= n_rem;
        r_q      <= n_q;
        r_lsb    <= n_lsb;
        r_neg    <= n_neg;
        r_n      <= n_n;
        r_u      <= n_u;
        r_w      <= n_w;
        r_ne     <= n_ne;
        r_dotv   <= n_dotv;
        r_degen  <= n_degen;
    end

    always_comb begin
        o_job.radius = r_radius;
        o_job.degen  = r_degen;
        for (int j = 0; j < 3; j++) begin
            o_job.base[j] = r_base[j];
            o_job.u[j]    = r_degen ? '0 : r_u[j];
            o_job.w[j]    = r_degen ? '0 : r_w[j];
            o_job.ne[j]   = r_degen ? '0 : r_ne[j];
        end
    end
endmodule

>>> sv/crvg_back.sv
module crvg_back import crvg_pkg::*; #(
    parameter int SLICE_COUNT = SLICE_COUNT_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_job             i_head,
    input  t_qstat           i_qstat,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [31:0]      o_pos_x,
    output logic [31:0]      o_pos_y,
    output logic [31:0]      o_pos_z,
    output logic             o_is_top,
    output logic [IDX_W-1:0] o_slice_index,
    output logic             o_degenerate,
    output logic             o_last
);
    localparam int Slices = slice_clamp(SLICE_COUNT);
    localparam int SW     = $clog2(Slices);

    logic signed [CS_W-1:0] w_cos [Slices];
    logic signed [CS_W-1:0] w_sin [Slices];

    for (genvar g = 0; g < Slices; g++) begin : g_tab
        localparam longint Phase = (longint'(g) << 32) / Slices;
        localparam logic [2*CS_W-1:0] Cs = cordic_cs(Phase);
        assign w_cos[g] = Cs[2*CS_W-1:CS_W];
        assign w_sin[g] = Cs[CS_W-1:0];
    end

    logic [SW-1:0] r_slice;
    logic          r_top;
    logic          w_adv, w_take, w_endv;

    logic                   r1_valid, r1_top, r1_degen, r1_last;
    logic [IDX_W-1:0]       r1_slice;
    logic signed [PT_W-1:0] r1_pt [3];
    logic signed [31:0]     r1_base [3];
    logic [30:0]            r1_radius;
    logic signed [NE_W-1:0] r1_ne [3];

    logic                    r2_valid, r2_top, r2_degen, r2_last;
    logic [IDX_W-1:0]        r2_slice;
    logic signed [ACC_W-1:0] r2_bot [3];
    logic signed [NE_W-1:0]  r2_ne [3];

    logic                   r_out_valid;
    logic [31:0]            r_pos [3];
    logic                   r_is_top, r_degen, r_last;
    logic [IDX_W-1:0]       r_sidx;

    logic signed [37:0]     w_uc [3];
    logic signed [39:0]     w_ws [3];
    logic signed [41:0]     w_rim [3];
    logic signed [57:0]     w_pr [3];
    logic signed [ACC_W-1:0] w_bot [3];
    logic signed [ACC_W-1:0] w_sum [3];

    assign w_adv  = !r_out_valid || i_out_ready;
    assign w_take = w_adv && !i_qstat.empty;
    assign w_endv = (r_slice == SW'(Slices - 1)) && r_top;
    assign o_pop  = w_take && w_endv;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_uc[j]  = $signed(i_head.u[j]) * w_cos[r_slice];
            w_ws[j]  = $signed(i_head.w[j]) * w_sin[r_slice];
            w_rim[j] = 42'(w_uc[j]) + 42'(w_ws[j]);
            w_pr[j]  = r1_pt[j] * $signed({1'b0, r1_radius});
            w_bot[j] = ACC_W'(r1_base[j]) + ACC_W'(w_pr[j] >>> 16);
            w_sum[j] = r2_bot[j] + ACC_W'(r2_ne[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slice     <= '0;
            r_top       <= 1'b0;
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r1_valid    <= !i_qstat.empty;
            r2_valid    <= r1_valid;
            r_out_valid <= r2_valid;
            if (w_take) begin
                r_top <= !r_top;
                if (w_endv)
                    r_slice <= '0;
                else if (r_top)
                    r_slice <= SW'(r_slice + 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_top    <= r_top;
            r1_degen  <= i_head.degen;
            r1_last   <= w_endv;
            r1_slice  <= IDX_W'(r_slice);
            r1_radius <= i_head.radius;
            for (int j = 0; j < 3; j++) begin
                r1_pt[j]   <= PT_W'(w_rim[j] >>> 16);
                r1_base[j] <= $signed(i_head.base[j]);
                r1_ne[j]   <= r_top ? $signed(i_head.ne[j]) : '0;
            end
            r2_top   <= r1_top;
            r2_degen <= r1_degen;
            r2_last  <= r1_last;
            r2_slice <= r1_slice;
            for (int j = 0; j < 3; j++) begin
                r2_bot[j] <= w_bot[j];
                r2_ne[j]  <= r1_ne[j];
            end
            r_is_top <= r2_top;
            r_degen  <= r2_degen;
            r_last   <= r2_last;
            r_sidx   <= r2_slice;
            for (int j = 0; j < 3; j++) r_pos[j] <= sat32(w_sum[j]);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pos_x       = r_pos[0];
    assign o_pos_y       = r_pos[1];
    assign o_pos_z       = r_pos[2];
    assign o_is_top      = r_is_top;
    assign o_slice_index = r_sidx;
    assign o_degenerate  = r_degen;
    assign o_last        = r_last;
endmodule
